// ----- hw/rtl/button_debounce_repeat_long_press_top_defines.svh -----
// Assertion macros shared by the button debouncer checker.
`ifndef BUTTON_DEBOUNCE_REPEAT_LONG_PRESS_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_REPEAT_LONG_PRESS_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define BDRLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BDRLP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/bdrlp_pkg.sv -----
// Types and constants of the button debouncer with auto-repeat and long press.
package bdrlp_pkg;

   // Item codes.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Field widths.
   localparam int RAW_WIDTH    = 2;
   localparam int SAMPLE_WIDTH = 10;
   localparam int EVENT_WIDTH  = 4;
   localparam int COUNT_WIDTH  = 11;
   localparam int WINDOW_WIDTH = SAMPLE_WIDTH + 2;

   // Register file layout.
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [2:0] REG_LONG_PRESS_MODE = 3'd0;
   localparam logic [2:0] REG_ANALOG_ENABLE   = 3'd1;
   localparam logic [2:0] REG_FIRST_CENTER    = 3'd2;
   localparam logic [2:0] REG_SECOND_CENTER   = 3'd3;
   localparam logic [2:0] REG_NOISE_MARGIN    = 3'd4;

   typedef logic signed [COUNT_WIDTH-1:0] count_type;
   typedef logic [SAMPLE_WIDTH-1:0] sample_type;

   // Register reset values.
   localparam sample_type FIRST_CENTER_RESET  = 10'd345;
   localparam sample_type SECOND_CENTER_RESET = 10'd254;
   localparam sample_type NOISE_MARGIN_RESET  = 10'h030;

   // Counter thresholds.
   localparam count_type COUNT_RESTART   = -11'sd4;
   localparam count_type DEBOUNCE_COUNT  = 11'sd3;
   localparam count_type HOLD_COUNT      = 11'sd100;
   localparam count_type WRAP_LIMIT      = 11'sd1000;
   localparam count_type WRAP_STEP       = 11'sd900;
   localparam count_type LONG_CAP        = 11'sd1001;
   localparam count_type SHORT_MIN_COUNT = 11'sd4;
   localparam count_type COUNT_FLOOR     = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   // Repeat period; the nibble-sum test below relies on it being 15.
   localparam logic [5:0] REPEAT_TICKS = 6'd15;

   // True when a positive count of at most 1023 is a multiple of 15.
   // Since 16 is 1 modulo 15, the sum of the hex digits keeps the residue.
   function automatic logic repeat_phase(input count_type value);
      logic [5:0] digit_sum;
      digit_sum = {2'b00, value[3:0]} + {2'b00, value[7:4]} + {4'b0000, value[9:8]};
      return (digit_sum == REPEAT_TICKS) || (digit_sum == 6'(2 * REPEAT_TICKS));
   endfunction

endpackage

// ----- hw/rtl/button_debounce_repeat_long_press_top.sv -----
// A read item passes through the input register and then the output register.
// Throughput: one item per cycle; a read waits in the input register while
// the previous result is still held in the output register, ticks pass on.
// The input register, output register and per-button counters form the path.
// Reset is synchronous: counters, latched events, configuration registers and valid flags take defaults.
module button_debounce_repeat_long_press_top
   import bdrlp_pkg::*;
#(
   parameter int NUM_BUTTONS = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input item channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [RAW_WIDTH-1:0]      req_raw_pressed,
   input  logic [SAMPLE_WIDTH-1:0]   req_adc_sample,
   // Result item channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [EVENT_WIDTH-1:0]    rsp_events,
   // Register port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // Configuration registers.
   logic       long_mode_ff;
   logic       analog_en_ff;
   sample_type first_center_ff;
   sample_type second_center_ff;
   sample_type margin_ff;
   logic       csr_write;
   logic [2:0] csr_index;

   // Input register.
   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   logic                    stage_opcode_ff;
   logic [RAW_WIDTH-1:0]    stage_raw_ff;
   sample_type              stage_sample_ff;
   logic                    stage_advance;
   logic                    out_free;

   // Button state.
   count_type               press_count_ff [NUM_BUTTONS];
   count_type               press_count_in [NUM_BUTTONS];
   logic [EVENT_WIDTH-1:0]  event_latch_ff;
   logic [EVENT_WIDTH-1:0]  event_latch_in;
   logic [EVENT_WIDTH-1:0]  tick_events;

   // Output register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [EVENT_WIDTH-1:0]  rsp_events_ff;
   logic                    rsp_load;

   // Register writes and reads decode the word index only.
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_mode_ff     <= 1'b0;
         analog_en_ff     <= 1'b0;
         first_center_ff  <= FIRST_CENTER_RESET;
         second_center_ff <= SECOND_CENTER_RESET;
         margin_ff        <= NOISE_MARGIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LONG_PRESS_MODE: long_mode_ff     <= csr_pwdata[0];
            REG_ANALOG_ENABLE:   analog_en_ff     <= csr_pwdata[0];
            REG_FIRST_CENTER:    first_center_ff  <= csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_SECOND_CENTER:   second_center_ff <= csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_NOISE_MARGIN:    margin_ff        <= csr_pwdata[SAMPLE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LONG_PRESS_MODE: csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, long_mode_ff};
         REG_ANALOG_ENABLE:   csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, analog_en_ff};
         REG_FIRST_CENTER:
            csr_prdata = {{(CSR_DATA_WIDTH-SAMPLE_WIDTH){1'b0}}, first_center_ff};
         REG_SECOND_CENTER:
            csr_prdata = {{(CSR_DATA_WIDTH-SAMPLE_WIDTH){1'b0}}, second_center_ff};
         REG_NOISE_MARGIN:
            csr_prdata = {{(CSR_DATA_WIDTH-SAMPLE_WIDTH){1'b0}}, margin_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // A tick can always leave the input register; a read needs a free output slot.
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign stage_advance  = stage_valid_ff && ((stage_opcode_ff == OP_TICK) || out_free);
   assign req_ready      = !stage_valid_ff || stage_advance;
   assign stage_valid_in = (req_valid && req_ready) || (stage_valid_ff && !stage_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_opcode_ff <= req_opcode;
         stage_raw_ff    <= req_raw_pressed;
         stage_sample_ff <= req_adc_sample;
      end
   end

   // Per-button counter update for one tick, all buttons in parallel.
   always_comb begin
      logic                            pressed;
      logic signed [WINDOW_WIDTH-1:0]  sample_ext;
      logic signed [WINDOW_WIDTH-1:0]  center_ext;
      logic signed [WINDOW_WIDTH-1:0]  margin_ext;
      count_type                       cnt;
      tick_events = '0;
      sample_ext  = $signed({2'b00, stage_sample_ff});
      margin_ext  = $signed({2'b00, margin_ff});
      for (int n = 0; n < NUM_BUTTONS; n++) begin
         center_ext = (n % 2 == 0) ? $signed({2'b00, first_center_ff})
                                   : $signed({2'b00, second_center_ff});
         pressed = stage_raw_ff[n] ||
                   (analog_en_ff && (sample_ext < center_ext + margin_ext) &&
                    (sample_ext > center_ext - margin_ext));
         cnt = press_count_ff[n];
         if (pressed) begin
            if (cnt < COUNT_RESTART) begin
               cnt = '0;
            end
            if (!long_mode_ff) begin
               // Debounce, then auto-repeat with the phase kept across the wrap.
               cnt = cnt + 11'sd1;
               if (cnt == DEBOUNCE_COUNT) begin
                  tick_events[n] = 1'b1;
               end else if (cnt > HOLD_COUNT && repeat_phase(cnt)) begin
                  tick_events[n] = 1'b1;
               end
               if (cnt > WRAP_LIMIT) begin
                  cnt = cnt - WRAP_STEP;
               end
            end else begin
               // One long event per hold, then the count parks at the cap.
               if (cnt > WRAP_LIMIT) begin
                  cnt = cnt;
               end else if (cnt > HOLD_COUNT) begin
                  tick_events[2*n+1] = 1'b1;
                  cnt = WRAP_LIMIT;
               end
               if (cnt < LONG_CAP) begin
                  cnt = cnt + 11'sd1;
               end
            end
         end else begin
            // Release: short event in long mode, then count released ticks.
            if (long_mode_ff && cnt <= HOLD_COUNT && cnt > SHORT_MIN_COUNT) begin
               tick_events[2*n] = 1'b1;
            end
            if (cnt > 11'sd0) begin
               cnt = '0;
            end
            if (cnt > COUNT_FLOOR) begin
               cnt = cnt - 11'sd1;
            end
         end
         press_count_in[n] = cnt;
      end
   end

   // A tick merges new events; a read hands them out and clears the latch.
   always_comb begin
      event_latch_in = event_latch_ff;
      if (stage_advance) begin
         if (stage_opcode_ff == OP_TICK) begin
            event_latch_in = event_latch_ff | tick_events;
         end else begin
            event_latch_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_latch_ff <= '0;
         for (int n = 0; n < NUM_BUTTONS; n++) begin
            press_count_ff[n] <= '0;
         end
      end else begin
         event_latch_ff <= event_latch_in;
         if (stage_advance && stage_opcode_ff == OP_TICK) begin
            for (int n = 0; n < NUM_BUTTONS; n++) begin
               press_count_ff[n] <= press_count_in[n];
            end
         end
      end
   end

   // Output register for the result of a read item.
   assign rsp_load     = stage_advance && (stage_opcode_ff == OP_READ);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_events_ff <= event_latch_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_events = rsp_events_ff;

endmodule

// ----- hw/rtl/bdrlp_checker.sv -----
// Port-level checker for the button debouncer, bound to its top level.
`include "button_debounce_repeat_long_press_top_defines.svh"

module bdrlp_checker
   import bdrlp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_opcode,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [EVENT_WIDTH-1:0] rsp_events,
   input logic                   csr_pready
);

   // Reset empties the output register.
   `BDRLP_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")

   // The register port never inserts wait states.
   `BDRLP_ASSERT_ALWAYS(a_pready_high, csr_pready, "pready dropped")

   // A new result must come from a read item accepted at the input, with no stall in the input register between.
   `BDRLP_ASSERT(a_result_from_read, $rose(rsp_valid) |-> ($past(req_valid && req_ready, 2) && ($past(req_opcode, 2) == OP_READ)), "result without an accepted read")

   // A stalled result holds its events.
   `BDRLP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_events)), "stalled result changed")

endmodule

bind button_debounce_repeat_long_press_top bdrlp_checker u_bdrlp_checker (.*);
